/* rtl/ordered_ready_queue_macros.svh */
`ifndef ORDERED_READY_QUEUE_MACROS_SVH
`define ORDERED_READY_QUEUE_MACROS_SVH

// same-cycle implication, checked outside reset
`define ORQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ordered_ready_queue: check failed");

// next-cycle implication, checked outside reset
`define ORQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ordered_ready_queue: check failed");

`endif

/* rtl/orq_pkg.sv */
`timescale 1ns / 1ps

package orq_pkg;

  localparam int DEPTH  = 16;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 8;
  localparam int TIME_W = 15;
  localparam int PRIO_W = 4;
  localparam int POL_W  = 2;

  localparam logic [POL_W-1:0] POL_FIFO = 2'd0;
  localparam logic [POL_W-1:0] POL_SJF  = 2'd1;
  localparam logic [POL_W-1:0] POL_PRIO = 2'd2;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  // 1.5 s with 8 fraction bits
  localparam logic [TIME_W-1:0] TIME_MARGIN = 15'd384;

  typedef struct packed {
    logic              mode;
    logic [ID_W-1:0]   entry_id;
    logic [TIME_W-1:0] exec_time;
    logic [PRIO_W-1:0] prio;
  } in_item_t;

  typedef struct packed {
    logic             removed_valid;
    logic [ID_W-1:0]  removed_id;
    logic             front_valid;
    logic [ID_W-1:0]  front_id;
    logic [CNT_W-1:0] occupancy;
    logic             dropped;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
  } orq_cmd_t;

endpackage

/* rtl/orq_ctrl.sv */
`timescale 1ns / 1ps

module orq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output logic              out_valid,
  output orq_pkg::orq_cmd_t cmd
);
  import orq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  // the update cycle does not block: the next item may be captured then
  assign busy   = (state_r == ST_CMP);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        out_valid_nxt = 1'b1;
        state_nxt     = accept ? ST_CMP : ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign cmd.capture = accept;
  assign cmd.compare = (state_r == ST_CMP);
  assign cmd.update  = (state_r == ST_UPD);

endmodule

/* rtl/orq_dp.sv */
`timescale 1ns / 1ps

module orq_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  orq_pkg::orq_cmd_t        cmd,
  input  orq_pkg::in_item_t        in_item,
  input  logic                     cfg_we,
  input  logic [orq_pkg::POL_W-1:0] cfg_wdata,
  output orq_pkg::out_item_t       out_item
);
  import orq_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] etime;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  logic [POL_W-1:0] policy_r;
  in_item_t         item_r;
  in_item_t         upd_item_r;
  entry_t           slot_r   [DEPTH];
  entry_t           slot_nxt [DEPTH];
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [DEPTH-1:0] beat;
  logic [DEPTH-1:0] ge_nxt;
  logic [DEPTH-1:0] ge_r;
  out_item_t        res_r;
  out_item_t        res_nxt;
  entry_t           new_entry;

  function automatic logic time_beats(logic [TIME_W-1:0] nt, logic [TIME_W-1:0] ht);
    logic [TIME_W:0] diff;
    diff = {1'b0, ht} - {1'b0, nt};
    return !diff[TIME_W] && (diff[TIME_W-1:0] >= TIME_MARGIN);
  endfunction

  function automatic logic beats(logic [POL_W-1:0] pol, in_item_t n, entry_t h);
    logic r;
    r = 1'b0;
    if (pol == POL_SJF) begin
      r = time_beats(n.exec_time, h.etime);
    end else if (pol == POL_PRIO) begin
      if (n.prio != h.prio) r = (n.prio < h.prio);
      else                  r = time_beats(n.exec_time, h.etime);
    end
    return r;
  endfunction

  // one compare cell per slot; ge marks the slots at or behind the insert point
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      beat[i] = (CNT_W'(i) < count_r) && beats(policy_r, item_r, slot_r[i]);
    end
    ge_nxt[0] = beat[0] || (count_r == '0);
    for (int i = 1; i < DEPTH; i++) begin
      ge_nxt[i] = ge_nxt[i-1] || beat[i] || (CNT_W'(i) >= count_r);
    end
  end

  assign new_entry.id    = upd_item_r.entry_id;
  assign new_entry.etime = upd_item_r.exec_time;
  assign new_entry.prio  = upd_item_r.prio;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) slot_nxt[i] = slot_r[i];
    count_nxt = count_r;
    res_nxt   = '0;
    if (upd_item_r.mode == MODE_REMOVE) begin
      if (count_r != '0) begin
        res_nxt.removed_valid = 1'b1;
        res_nxt.removed_id    = slot_r[0].id;
        for (int i = 0; i < DEPTH - 1; i++) slot_nxt[i] = slot_r[i+1];
        count_nxt = count_r - CNT_W'(1);
      end
    end else if (count_r == CNT_W'(DEPTH)) begin
      res_nxt.dropped = 1'b1;
    end else begin
      if (ge_r[0]) slot_nxt[0] = new_entry;
      for (int i = 1; i < DEPTH; i++) begin
        if (ge_r[i]) slot_nxt[i] = ge_r[i-1] ? slot_r[i-1] : new_entry;
      end
      count_nxt = count_r + CNT_W'(1);
    end
    res_nxt.front_valid = (count_nxt != '0);
    res_nxt.front_id    = (count_nxt != '0) ? slot_nxt[0].id : '0;
    res_nxt.occupancy   = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIFO;
      count_r  <= '0;
    end else begin
      if (cfg_we)     policy_r <= cfg_wdata;
      if (cmd.update) count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    if (cmd.compare) begin
      ge_r       <= ge_nxt;
      upd_item_r <= item_r;
    end
    if (cmd.update) begin
      res_r <= res_nxt;
      for (int i = 0; i < DEPTH; i++) slot_r[i] <= slot_nxt[i];
    end
  end

  assign out_item = res_r;

endmodule

/* rtl/ordered_ready_queue.sv */
`timescale 1ns / 1ps
// channel   ports                         direction  handshake
// input     start, busy, in_item          in         start && !busy
// result    out_valid, out_item           out        one-cycle strobe
// config    cfg_we, cfg_wdata             in         cfg_we
//
// An item passes a compare cycle across the row of slot cells,
// then an update cycle that shifts the slots and registers the result.
// busy is high only in the compare cycle, so the next item can be captured in the update cycle.
// The result strobe comes in the cycle after the update cycle.
// Synchronous active-low reset empties the queue and sets fifo policy.
// The receiver cannot stall; no buffering beyond the result register.

`include "ordered_ready_queue_macros.svh"

module ordered_ready_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  orq_pkg::in_item_t         in_item,
  output logic                      out_valid,
  output orq_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [orq_pkg::POL_W-1:0] cfg_wdata
);
  import orq_pkg::*;

  orq_cmd_t cmd;

  orq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  orq_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_item  (out_item)
  );

  `ORQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ORQ_ASSERT_NEXT(a_strobe_gap, out_valid, !out_valid)
  `ORQ_ASSERT_NOW(a_front_occ, out_valid, out_item.front_valid == (out_item.occupancy != '0))
  `ORQ_ASSERT_NOW(a_drop_full, out_valid && out_item.dropped,
                  (out_item.occupancy == CNT_W'(DEPTH)) && !out_item.removed_valid)

endmodule

/* verif/ordered_ready_queue_test.sv */
`timescale 1ns / 1ps

module ordered_ready_queue_test;
  import orq_pkg::*;

  // policy code with no name of its own; behaves as fifo
  localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_LIMIT  = 1000;
  localparam int SETTLE       = 6;
  localparam int PRINT_CAP    = 60;
  localparam int CLOSING      = 150;
  localparam int IN_W         = $bits(in_item_t);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] exec_time;
    logic [PRIO_W-1:0] prio;
  } slot_t;

  typedef enum logic {ROW_CONFIG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [POL_W-1:0] pol;
    in_item_t         item;
    bit               known;
    out_item_t        result;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_item = '0;
  logic             out_valid;
  out_item_t        out_item;
  logic             cfg_we = 1'b0;
  logic [POL_W-1:0] cfg_wdata = '0;

  // predicted queue contents
  slot_t            held_slots [DEPTH];
  logic [3:0]       held_head = '0;
  int unsigned      held_count = 0;
  logic [POL_W-1:0] active_policy = POL_FIFO;

  out_item_t   expected_results [$];
  int unsigned mismatch_count = 0;
  int unsigned result_index = 0;
  int unsigned cycle_count = 0;

  ordered_ready_queue uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[ordered_ready_queue] ERROR");
      $finish;
    end
  end

  function automatic logic [3:0] ring_slot(int unsigned offset);
    return 4'((held_head + offset) % DEPTH);
  endfunction

  function automatic bit time_wins(logic [TIME_W-1:0] fresh, logic [TIME_W-1:0] held);
    return (held >= fresh) && ((held - fresh) >= TIME_MARGIN);
  endfunction

  function automatic bit ranks_ahead(slot_t fresh, slot_t held);
    if (active_policy == POL_SJF) return time_wins(fresh.exec_time, held.exec_time);
    if (active_policy == POL_PRIO) begin
      if (fresh.prio != held.prio) return fresh.prio < held.prio;
      return time_wins(fresh.exec_time, held.exec_time);
    end
    return 1'b0;
  endfunction

  function automatic out_item_t predict_queue_step(in_item_t it);
    out_item_t   res;
    slot_t       fresh;
    int unsigned pos;
    res = '0;
    fresh.id = it.entry_id;
    fresh.exec_time = it.exec_time;
    fresh.prio = it.prio;
    if (it.mode == MODE_REMOVE) begin
      if (held_count > 0) begin
        res.removed_valid = 1'b1;
        res.removed_id = held_slots[held_head].id;
        held_head = ring_slot(1);
        held_count--;
      end
    end else if (held_count >= DEPTH) begin
      res.dropped = 1'b1;
    end else begin
      pos = held_count;
      if (active_policy == POL_SJF || active_policy == POL_PRIO) begin
        for (int i = 0; i < held_count; i++) begin
          if (ranks_ahead(fresh, held_slots[ring_slot(i)])) begin
            pos = i;
            break;
          end
        end
      end
      for (int i = held_count; i > pos; i--)
        held_slots[ring_slot(i)] = held_slots[ring_slot(i - 1)];
      held_slots[ring_slot(pos)] = fresh;
      held_count++;
    end
    res.front_valid = (held_count > 0);
    res.front_id = (held_count > 0) ? held_slots[held_head].id : '0;
    res.occupancy = CNT_W'(held_count);
    return res;
  endfunction

  // favours times close to held ones so the 1.5 s margin gets exercised
  function automatic logic [TIME_W-1:0] pick_exec_time();
    int base;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel inside {[3:6]} && held_count > 0) begin
      base = held_slots[ring_slot($urandom_range(0, held_count - 1))].exec_time;
      case ($urandom_range(0, 3))
        0: base = base - 384;
        1: base = base - 383;
        2: base = base + $urandom_range(0, 500);
        default: base = base - $urandom_range(0, 1500);
      endcase
      if (base < 0) base = 0;
      if (base > 32767) base = 32767;
      return TIME_W'(base);
    end
    if (sel == 7) return '0;
    if (sel == 8) return '1;
    if (sel == 9) return TIME_W'($urandom_range(0, 1000));
    return TIME_W'($urandom_range(0, 32767));
  endfunction

  function automatic stim_row_t policy_row(logic [POL_W-1:0] p);
    stim_row_t r;
    r = '{kind: ROW_CONFIG, pol: p, item: '0, known: 1'b0, result: '0};
    return r;
  endfunction

  function automatic stim_row_t item_row(logic m, int id, int t, int pr);
    stim_row_t r;
    r = '{kind: ROW_ITEM, pol: '0, item: '0, known: 1'b0, result: '0};
    r.item = '{mode: m, entry_id: ID_W'(id), exec_time: TIME_W'(t), prio: PRIO_W'(pr)};
    return r;
  endfunction

  function automatic stim_row_t known_row(logic m, int id, int t, int pr, out_item_t e);
    stim_row_t r;
    r = item_row(m, id, t, pr);
    r.known = 1'b1;
    r.result = e;
    return r;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatch_count < PRINT_CAP)
      $display("result %0d: %0s got %0d want %0d", result_index, field, got, want);
    mismatch_count++;
  endtask

  task automatic hold_off(int unsigned cycles);
    start <= 1'b0;
    in_item <= IN_W'($urandom());
    repeat (cycles) @(posedge clk);
  endtask

  // idle means every expected result has come back, plus the pipeline tail
  task automatic write_policy(logic [POL_W-1:0] p);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we <= 1'b0;
    active_policy = p;
  endtask

  task automatic send_item(in_item_t it, bit known, out_item_t typed);
    out_item_t pred;
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    pred = predict_queue_step(it);
    expected_results.push_back(known ? typed : pred);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected item, front_id", out_item.front_id, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_item.removed_valid !== want.removed_valid)
          report_mismatch("removed_valid", out_item.removed_valid, want.removed_valid);
        if (out_item.removed_id !== want.removed_id)
          report_mismatch("removed_id", out_item.removed_id, want.removed_id);
        if (out_item.front_valid !== want.front_valid)
          report_mismatch("front_valid", out_item.front_valid, want.front_valid);
        if (out_item.front_id !== want.front_id)
          report_mismatch("front_id", out_item.front_id, want.front_id);
        if (out_item.occupancy !== want.occupancy)
          report_mismatch("occupancy", out_item.occupancy, want.occupancy);
        if (out_item.dropped !== want.dropped)
          report_mismatch("dropped", out_item.dropped, want.dropped);
      end
      result_index++;
    end
  end

  initial begin
    stim_row_t   plan [$];
    in_item_t    it;
    int unsigned sent;
    int unsigned phase_len;
    int unsigned insert_pct;
    int unsigned drain_wait;
    bit          narrow_prio;
    bit          gaps_on;

    for (int i = 0; i < DEPTH; i++) held_slots[i] = '0;

    // empty, extremes and fifo order
    plan.push_back(policy_row(POL_FIFO));
    plan.push_back(known_row(MODE_REMOVE, 0, 0, 0, '{1'b0, 8'd0, 1'b0, 8'd0, 5'd0, 1'b0}));
    plan.push_back(known_row(MODE_INSERT, 255, 32767, 15,
                             '{1'b0, 8'd0, 1'b1, 8'd255, 5'd1, 1'b0}));
    plan.push_back(known_row(MODE_INSERT, 0, 0, 0, '{1'b0, 8'd0, 1'b1, 8'd255, 5'd2, 1'b0}));
    plan.push_back(known_row(MODE_REMOVE, 9, 9, 9, '{1'b1, 8'd255, 1'b1, 8'd0, 5'd1, 1'b0}));
    plan.push_back(known_row(MODE_REMOVE, 9, 9, 9, '{1'b1, 8'd0, 1'b0, 8'd0, 5'd0, 1'b0}));
    // shortest time: margin one short, exactly met, larger time
    plan.push_back(policy_row(POL_SJF));
    plan.push_back(item_row(MODE_INSERT, 10, 1000, 5));
    plan.push_back(item_row(MODE_INSERT, 11, 617, 5));
    plan.push_back(item_row(MODE_INSERT, 12, 616, 5));
    plan.push_back(item_row(MODE_INSERT, 13, 2000, 5));
    // priority, then time on equal priority
    plan.push_back(policy_row(POL_PRIO));
    plan.push_back(item_row(MODE_INSERT, 20, 5000, 3));
    plan.push_back(item_row(MODE_INSERT, 21, 4616, 3));
    plan.push_back(item_row(MODE_INSERT, 22, 4617, 3));
    // spare code acts as fifo; held order is kept across the change
    plan.push_back(policy_row(POL_SPARE));
    plan.push_back(item_row(MODE_INSERT, 30, 0, 0));
    for (int i = 0; i < 8; i++)
      plan.push_back(item_row(MODE_INSERT, 40 + i, 4000 * i + 7, 15 - 2 * i));
    plan.push_back(known_row(MODE_INSERT, 99, 1, 0, '{1'b0, 8'd0, 1'b1, 8'd21, 5'd16, 1'b1}));
    plan.push_back(known_row(MODE_REMOVE, 0, 0, 0, '{1'b1, 8'd21, 1'b1, 8'd20, 5'd15, 1'b0}));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CONFIG) begin
        write_policy(plan[i].pol);
      end else begin
        if ($urandom_range(0, 2) == 0) hold_off($urandom_range(1, 8));
        send_item(plan[i].item, plan[i].known, plan[i].result);
      end
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      write_policy(POL_W'($urandom_range(0, 3)));
      phase_len = $urandom_range(20, 80);
      // the closing stretch is one phase, so no policy write idles it
      if (sent + CLOSING >= RANDOM_ITEMS) phase_len = RANDOM_ITEMS - sent;
      case ($urandom_range(0, 3))
        0: insert_pct = 25;
        1: insert_pct = 50;
        2: insert_pct = 75;
        default: insert_pct = 95;
      endcase
      narrow_prio = $urandom_range(0, 1);
      // no idling in the closing stretch
      gaps_on = (sent + CLOSING < RANDOM_ITEMS) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
        it.mode = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
        it.entry_id = ID_W'($urandom_range(0, 255));
        it.exec_time = pick_exec_time();
        it.prio = narrow_prio ? PRIO_W'($urandom_range(0, 2)) : PRIO_W'($urandom_range(0, 15));
        if (gaps_on && sent + CLOSING < RANDOM_ITEMS && $urandom_range(0, 2) == 0)
          hold_off($urandom_range(1, 8));
        send_item(it, 1'b0, '0);
        sent++;
      end
    end

    start <= 1'b0;
    drain_wait = 0;
    while (expected_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("items never returned", 0, expected_results.size());

    if (mismatch_count == 0) begin
      $display("[ordered_ready_queue] OK");
    end else begin
      $display("[ordered_ready_queue] ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/orq_pkg.sv
rtl/orq_ctrl.sv
rtl/orq_dp.sv
rtl/ordered_ready_queue.sv
verif/ordered_ready_queue_test.sv
